FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk with rst as disable; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a full property expression every clock.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

FILE: hdl/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// Min/max bucket decimator package
// Widths, reset constants, register indexes and beat types.
// ----------------------------------------------------------------------------
package mmbd_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int VALUE_BITS     = 32;
  localparam int TIME_BITS      = 48;
  localparam int MAX_BITS       = 12;
  localparam int BUCKET_DIV     = 2;
  localparam int BUCKET_BITS    = MAX_BITS - 1;
  localparam int STEP_BITS      = $clog2(COUNT_BITS);
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  localparam int TOTAL_RESET    = 1;
  localparam int MAX_RESET      = 1024;
  localparam int RESET_BUCKETS  = MAX_RESET / BUCKET_DIV;
  localparam int QUOT_RESET     = TOTAL_RESET / RESET_BUCKETS;
  localparam int REM_RESET      = TOTAL_RESET % RESET_BUCKETS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TOTAL_POINTS = CFG_INDEX_BITS'(0),
    REG_MAX_POINTS   = CFG_INDEX_BITS'(1)
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ONE,
    EMIT_TWO
  } emit_count_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]         point_time;
    logic signed [VALUE_BITS-1:0] point_value;
  } point_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]         out_time;
    logic signed [VALUE_BITS-1:0] out_value;
    logic                         run_last;
  } result_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  total_points;
    logic [MAX_BITS-1:0]    max_points;
    logic [BUCKET_BITS-1:0] buckets;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  quot;
    logic [BUCKET_BITS-1:0] rem;
    logic                   busy;
    logic                   done;
  } div_status_t;

  typedef struct packed {
    emit_count_t count;
    result_t     first;
    result_t     second;
  } emit_t;

  // Bucket count is half of max_points, never below one.
  function automatic logic [BUCKET_BITS-1:0] bucket_count(input logic [MAX_BITS-1:0] max_pts);
    logic [MAX_BITS-1:0] half;
    half = MAX_BITS'(max_pts / BUCKET_DIV);
    return (half == '0) ? BUCKET_BITS'(1) : half[BUCKET_BITS-1:0];
  endfunction

endpackage

FILE: hdl/mmbd_divider.sv
// ----------------------------------------------------------------------------
// Boundary divider
// Restoring radix-2 divider, one quotient bit per cycle, for total/buckets.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmbd_divider
  import mmbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COUNT_BITS-1:0]  dividend,
  input  logic [BUCKET_BITS-1:0] divisor,
  output div_status_t            status
);

  logic [COUNT_BITS-1:0]  quot;
  logic [BUCKET_BITS-1:0] rem;
  logic [STEP_BITS-1:0]   step;
  logic                   busy;
  logic                   done;
  logic [BUCKET_BITS:0]   trial;
  logic                   fits;

  always_comb begin
    trial = {rem, quot[COUNT_BITS-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quot <= COUNT_BITS'(QUOT_RESET);
      rem  <= BUCKET_BITS'(REM_RESET);
      step <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        rem  <= '0;
        step <= STEP_BITS'(COUNT_BITS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        // shift the next quotient bit in, the next dividend bit out
        quot <= {quot[COUNT_BITS-2:0], fits};
        rem  <= fits ? BUCKET_BITS'(trial - {1'b0, divisor}) : trial[BUCKET_BITS-1:0];
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - STEP_BITS'(1);
        end
      end
    end
  end

  assign status = '{quot: quot, rem: rem, busy: busy, done: done};

  `ASSERT_IMPL(a_done_follows_busy, done, $past(busy), "divider done without a division")

endmodule

FILE: hdl/mmbd_tracker.sv
// ----------------------------------------------------------------------------
// Bucket tracker
// Position counter, boundary accumulator and min/max of the open bucket.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmbd_tracker
  import mmbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  point_t      pt,
  input  cfg_t        cfg,
  input  div_status_t div,
  output emit_t       emit
);

  logic [COUNT_BITS-1:0]        points_seen, points_seen_next;
  logic [COUNT_BITS-1:0]        bucket_end, bucket_end_next;
  logic [BUCKET_BITS-1:0]       boundary_remainder, boundary_remainder_next;
  logic                         bucket_open, bucket_open_next;
  logic signed [VALUE_BITS-1:0] min_value, min_value_next;
  logic signed [VALUE_BITS-1:0] max_value, max_value_next;
  logic [TIME_BITS-1:0]         min_time, min_time_next;
  logic [TIME_BITS-1:0]         max_time, max_time_next;
  logic [COUNT_BITS-1:0]        min_position, min_position_next;
  logic [COUNT_BITS-1:0]        max_position, max_position_next;

  logic                         passthrough;
  logic                         take_min;
  logic                         take_max;
  logic                         bucket_done;
  logic                         run_done;
  logic                         wrap;
  logic [COUNT_BITS-1:0]        seen_inc;
  logic [COUNT_BITS-1:0]        end_sum;
  logic [BUCKET_BITS:0]         rem_sum;
  result_t                      min_beat;
  result_t                      max_beat;

  always_comb begin
    passthrough = cfg.total_points <= COUNT_BITS'(cfg.max_points);
    seen_inc    = points_seen + COUNT_BITS'(1);
    run_done    = seen_inc >= cfg.total_points;
    bucket_done = seen_inc >= bucket_end;
    take_min    = !bucket_open || ($signed(pt.point_value) < $signed(min_value));
    take_max    = !bucket_open || ($signed(pt.point_value) > $signed(max_value));

    min_value_next    = take_min ? pt.point_value : min_value;
    min_time_next     = take_min ? pt.point_time  : min_time;
    min_position_next = take_min ? points_seen    : min_position;
    max_value_next    = take_max ? pt.point_value : max_value;
    max_time_next     = take_max ? pt.point_time  : max_time;
    max_position_next = take_max ? points_seen    : max_position;

    // advance the boundary by quotient, carry the remainder
    rem_sum = {1'b0, boundary_remainder} + {1'b0, div.rem};
    wrap    = rem_sum >= {1'b0, cfg.buckets};
    end_sum = bucket_end + div.quot + COUNT_BITS'(wrap);

    min_beat = '{out_time: min_time_next, out_value: min_value_next, run_last: 1'b1};
    max_beat = '{out_time: max_time_next, out_value: max_value_next, run_last: 1'b1};

    emit.count  = EMIT_NONE;
    emit.first  = min_beat;
    emit.second = max_beat;
    if (passthrough) begin
      emit.count = EMIT_ONE;
      emit.first = '{out_time: pt.point_time, out_value: pt.point_value, run_last: 1'b1};
    end else if (bucket_done) begin
      if (min_position_next == max_position_next) begin
        emit.count = EMIT_ONE;
      end else if (min_position_next < max_position_next) begin
        emit.count          = EMIT_TWO;
        emit.first.run_last = 1'b0;
      end else begin
        emit.count           = EMIT_TWO;
        emit.first           = max_beat;
        emit.first.run_last  = 1'b0;
        emit.second          = min_beat;
      end
    end

    points_seen_next        = points_seen;
    bucket_end_next         = bucket_end;
    boundary_remainder_next = boundary_remainder;
    bucket_open_next        = bucket_open;
    if (fire) begin
      points_seen_next = seen_inc;
      if (!passthrough) begin
        bucket_open_next = 1'b1;
        if (bucket_done) begin
          bucket_end_next         = end_sum;
          boundary_remainder_next = wrap ? BUCKET_BITS'(rem_sum - {1'b0, cfg.buckets})
                                         : rem_sum[BUCKET_BITS-1:0];
          bucket_open_next        = 1'b0;
        end
      end
    end
    // restart the run at its end or once new boundaries are ready
    if ((fire && run_done) || div.done) begin
      points_seen_next        = '0;
      bucket_end_next         = div.quot;
      boundary_remainder_next = div.rem;
      bucket_open_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen        <= '0;
      bucket_end         <= COUNT_BITS'(QUOT_RESET);
      boundary_remainder <= BUCKET_BITS'(REM_RESET);
      bucket_open        <= 1'b0;
    end else begin
      points_seen        <= points_seen_next;
      bucket_end         <= bucket_end_next;
      boundary_remainder <= boundary_remainder_next;
      bucket_open        <= bucket_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !passthrough) begin
      min_value    <= min_value_next;
      min_time     <= min_time_next;
      min_position <= min_position_next;
      max_value    <= max_value_next;
      max_time     <= max_time_next;
      max_position <= max_position_next;
    end
  end

  `ASSERT_IMPL(a_pass_one_beat, fire && passthrough, emit.count == EMIT_ONE,
               "pass-through point must give exactly one beat")
  `ASSERT_CLK(a_close_on_emit, fire && !passthrough && bucket_done |=> !bucket_open,
              "bucket still open after its end")

endmodule

FILE: hdl/mmbd_out_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-slot output register; holds both beats of a closing bucket.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmbd_out_buf
  import mmbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  emit_t   emit,
  output logic    space,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data
);

  emit_count_t fill;
  result_t     head;
  result_t     tail;
  logic        pop;

  assign res_valid = fill != EMIT_NONE;
  assign res_data  = head;
  assign pop       = res_valid && res_ready;
  // take new beats only when the buffer drains empty this cycle
  assign space     = (fill == EMIT_NONE) || ((fill == EMIT_ONE) && res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= EMIT_NONE;
    end else if (push) begin
      fill <= emit.count;
    end else if (pop) begin
      fill <= (fill == EMIT_TWO) ? EMIT_ONE : EMIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      head <= emit.first;
      tail <= emit.second;
    end else if (pop) begin
      head <= tail;
    end
  end

  `ASSERT_CLK(a_pair_head_not_last, push && emit.count == EMIT_TWO |=> res_valid && !res_data.run_last,
              "first beat of a pair flagged as last")

endmodule

FILE: hdl/min_max_bucket_decimator_core.sv
// ----------------------------------------------------------------------------
// Min/max bucket decimator core
// Peak-detect decimation of a (time, value) point stream into min/max pairs.
// ----------------------------------------------------------------------------
// Usage:
//   pt channel  : one point per beat (48-bit time, signed Q21.10 value).
//   res channel : emitted points; run_last marks the last beat caused by a point.
//   cfg channel : register writes, index 0 = total_points, index 1 = max_points.
//   With total_points <= max_points every point passes through unchanged.
//   Otherwise the run is cut into max_points/2 buckets and each closing bucket
//   emits its first minimum and first maximum in time order (one beat if same).
// Timing:
//   A point is registered into the result buffer at acceptance; its first beat
//   shows in the cycle after. One point per cycle is sustained while res_ready
//   is high and no write is pending; a bucket that closes with two beats holds
//   pt_ready low until its first beat is taken. A register write restarts the
//   run and reruns the boundary divider (one quotient bit a cycle) with pt_ready low.
// Reset: registers return to total_points = 1, max_points = 1024 with the
//   boundaries preset; points are taken from the first cycle after reset.
// Stall: while res_ready is low, results hold and pt_ready falls once the
//   buffer cannot take a further point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_max_bucket_decimator_core
  import mmbd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pt_valid,
  output logic                      pt_ready,
  input  point_t                    pt_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output result_t                   res_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [COUNT_BITS-1:0] total_points;
  logic [MAX_BITS-1:0]   max_points;
  logic                  div_start;
  logic                  cfg_fire;
  logic                  pt_fire;
  logic                  space;
  cfg_t                  cfg;
  div_status_t           div;
  emit_t                 emit;

  // Registers are always writable; a write only restarts the run.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_points <= COUNT_BITS'(TOTAL_RESET);
      max_points   <= MAX_BITS'(MAX_RESET);
      div_start    <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TOTAL_POINTS: begin
            total_points <= cfg_data[COUNT_BITS-1:0];
            div_start    <= 1'b1;
          end
          REG_MAX_POINTS: begin
            max_points <= cfg_data[MAX_BITS-1:0];
            div_start  <= 1'b1;
          end
          default: begin
            // drop writes beyond the register list
          end
        endcase
      end
    end
  end

  assign cfg = '{total_points: total_points,
                 max_points:   max_points,
                 buckets:      bucket_count(max_points)};

  // Hold off points while boundaries are recomputed and the run restarts.
  assign pt_ready = space && !div_start && !div.busy && !div.done;
  assign pt_fire  = pt_valid && pt_ready;

  mmbd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cfg.total_points),
    .divisor  (cfg.buckets),
    .status   (div)
  );

  mmbd_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .fire (pt_fire),
    .pt   (pt_data),
    .cfg  (cfg),
    .div  (div),
    .emit (emit)
  );

  mmbd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (pt_fire),
    .emit      (emit),
    .space     (space),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  `ASSERT_CLK(a_cfg_blocks_points, cfg_fire && (cfg_index == REG_TOTAL_POINTS || cfg_index == REG_MAX_POINTS) |=> !pt_ready,
              "point accepted right after a register write")

endmodule
